// ----- rtl/glyph_pixel_colorizer_assert.svh -----
// assertion macros shared by the glyph colorizer rtl
// no dependencies; included by the modules that carry assertions
`ifndef GLYPH_PIXEL_COLORIZER_ASSERT_SVH
`define GLYPH_PIXEL_COLORIZER_ASSERT_SVH

// same-cycle implication, ignored while reset is high
`define GPC_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gpc assertion failed");

// next-cycle implication, ignored while reset is high
`define GPC_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gpc assertion failed");

`endif

// ----- rtl/gpc_pkg.sv -----
// shared types and constants of the glyph pixel colorizer
// no dependencies; imported by the top, palette and channel modules of the block
`default_nettype none

package gpc_pkg;

  localparam int CHAN_W      = 8;
  localparam int COLOR_W     = 3 * CHAN_W;
  localparam int PAIR_W      = 2 * COLOR_W;
  localparam int PAL_PAIRS   = 8;
  localparam int PAIR_IDX_W  = $clog2(PAL_PAIRS);
  localparam int CFG_IDX_W   = PAIR_IDX_W + 1;
  localparam int FG_IDX_W    = PAIR_IDX_W + 1;
  localparam int BG_IDX_W    = PAIR_IDX_W;
  localparam int CODE_W      = 3;

  // blend arithmetic: numerator up to 255^3 plus rounding fits in 24 bits
  localparam int NUM_W       = 3 * CHAN_W;
  localparam logic [NUM_W-1:0] ROUND_HALF = NUM_W'(32512);
  localparam logic [NUM_W-1:0] FULL_SCALE = NUM_W'(65025);

  // channel products and the remainder left by the shift estimate
  localparam int PROD_W      = 2 * CHAN_W;
  // remainder after subtracting the shift estimate stays below 2^18
  localparam int REM_W       = PROD_W + 2;
  localparam logic [REM_W-1:0] ONE_R = REM_W'(FULL_SCALE);
  localparam logic [REM_W-1:0] TWO_R = REM_W'(2 * FULL_SCALE);

  // channel pipeline: product, product, sum, remainder, correction
  localparam int CHAN_STAGES = 5;
  // input register and palette read come first
  localparam int LAT         = 2 + CHAN_STAGES;

  localparam logic [CHAN_W-1:0]  CHAN_MAX  = {CHAN_W{1'b1}};
  localparam logic [CHAN_W-1:0]  KEY_ALPHA = 8'hFF;
  localparam logic [COLOR_W-1:0] KEY_RGB   = 24'hFF00FF;

  // palette lookup for one pixel
  typedef struct packed {
    logic [FG_IDX_W-1:0] fg_idx;
    logic [BG_IDX_W-1:0] bg_idx;
  } pal_req_t;

  // configuration write transaction
  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] idx;
    logic [PAIR_W-1:0]    data;
  } cfg_wr_t;

endpackage

`default_nettype wire

// ----- rtl/glyph_pixel_colorizer.sv -----
// top level of the glyph pixel colorizer: input stage, palette, three channels
// depends on gpc_pkg, gpc_palette, gpc_chan_blend and the assertion macro header
`default_nettype none
`include "glyph_pixel_colorizer_assert.svh"

// Takes one glyph pixel per clock: busy stays low, so every cycle with start
// high is a transaction. Each pixel comes out with done high for a single
// cycle; the receiver cannot hold results off. A pixel passes through the
// pipeline in order: input register, palette ram read, two multiplier
// stages, rounded sum, remainder, and quotient correction. The palette lives
// in eight 48-bit pair entries of a ram (index 0 to 7 on the cfg port,
// cfg_ready always high); a pair never written reads as black. Write the
// palette only while no pixel is in flight.
module glyph_pixel_colorizer (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic [gpc_pkg::CHAN_W-1:0]      glyph_alpha,
  input  wire logic [gpc_pkg::CHAN_W-1:0]      glyph_red,
  input  wire logic [gpc_pkg::CHAN_W-1:0]      glyph_green,
  input  wire logic [gpc_pkg::CHAN_W-1:0]      glyph_blue,
  input  wire logic [gpc_pkg::CODE_W-1:0]      fg_code,
  input  wire logic                            fg_bright,
  input  wire logic [gpc_pkg::CODE_W-1:0]      bg_code,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [gpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [gpc_pkg::PAIR_W-1:0]      cfg_data,
  output logic                                 done,
  output logic      [gpc_pkg::CHAN_W-1:0]      out_red,
  output logic      [gpc_pkg::CHAN_W-1:0]      out_green,
  output logic      [gpc_pkg::CHAN_W-1:0]      out_blue,
  output logic                                 is_key_pixel
);
  import gpc_pkg::*;

  logic              take;
  logic              key_in;
  logic [LAT:1]      vld;
  logic [LAT:2]      key_s;
  logic              key1;
  logic [CHAN_W-1:0] a1;
  logic [CHAN_W-1:0] r1;
  logic [CHAN_W-1:0] g1;
  logic [CHAN_W-1:0] b1;
  logic [CHAN_W-1:0] a2;
  logic [CHAN_W-1:0] r2;
  logic [CHAN_W-1:0] g2;
  logic [CHAN_W-1:0] b2;
  pal_req_t          req1;
  cfg_wr_t           cfg;
  logic [COLOR_W-1:0] fg_color;
  logic [COLOR_W-1:0] bg_color;
  logic [COLOR_W-1:0] fg_eff;
  logic [CHAN_W-1:0]  r_eff;
  logic [CHAN_W-1:0]  g_eff;
  logic [CHAN_W-1:0]  b_eff;

  // the pipeline never stalls
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign take      = start && !busy;

  assign key_in = (glyph_alpha == KEY_ALPHA) &&
                  ({glyph_red, glyph_green, glyph_blue} == KEY_RGB);

  // valid bits move with the pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-1:1], take};
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    a1          <= glyph_alpha;
    r1          <= glyph_red;
    g1          <= glyph_green;
    b1          <= glyph_blue;
    key1        <= key_in;
    req1.fg_idx <= {fg_bright, fg_code};
    req1.bg_idx <= bg_code;
  end

  // pixel data waits alongside the palette read; key flag runs to the end
  always_ff @(posedge clk) begin
    a2    <= a1;
    r2    <= r1;
    g2    <= g1;
    b2    <= b1;
    key_s <= {key_s[LAT-1:2], key1};
  end

  assign cfg.we   = cfg_valid && cfg_ready;
  assign cfg.idx  = cfg_index;
  assign cfg.data = cfg_data;

  gpc_palette u_palette (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .req      (req1),
    .fg_color (fg_color),
    .bg_color (bg_color)
  );

  // key pixel: blend full glyph with bg as fg, which yields bg exactly
  assign fg_eff = key_s[2] ? bg_color : fg_color;
  assign r_eff  = key_s[2] ? CHAN_MAX : r2;
  assign g_eff  = key_s[2] ? CHAN_MAX : g2;
  assign b_eff  = key_s[2] ? CHAN_MAX : b2;

  gpc_chan_blend u_red (
    .clk   (clk),
    .alpha (a2),
    .glyph (r_eff),
    .fg    (fg_eff[3*CHAN_W-1:2*CHAN_W]),
    .bg    (bg_color[3*CHAN_W-1:2*CHAN_W]),
    .quot  (out_red)
  );

  gpc_chan_blend u_green (
    .clk   (clk),
    .alpha (a2),
    .glyph (g_eff),
    .fg    (fg_eff[2*CHAN_W-1:CHAN_W]),
    .bg    (bg_color[2*CHAN_W-1:CHAN_W]),
    .quot  (out_green)
  );

  gpc_chan_blend u_blue (
    .clk   (clk),
    .alpha (a2),
    .glyph (b_eff),
    .fg    (fg_eff[CHAN_W-1:0]),
    .bg    (bg_color[CHAN_W-1:0]),
    .quot  (out_blue)
  );

  assign done         = vld[LAT];
  assign is_key_pixel = key_s[LAT];

  // every result traces back to a transaction a fixed latency earlier
  `GPC_ASSERT_IMP(a_done_from_start, clk, rst, done, $past(take, LAT))

  // the key flag of a result matches the pixel that was taken
  `GPC_ASSERT_IMP(a_key_follows, clk, rst, done, is_key_pixel == $past(key_in, LAT))

endmodule

`default_nettype wire

// ----- rtl/gpc_ram.sv -----
// generic ram: one write port, two read ports with registered read data
// no dependencies
`default_nettype none

module gpc_ram #(
  parameter int W = 8,
  parameter int D = 8
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr_a,
  output logic      [W-1:0]         rdata_a,
  input  wire logic [$clog2(D)-1:0] raddr_b,
  output logic      [W-1:0]         rdata_b
);

  logic [W-1:0] mem [D];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read ports
  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

// ----- rtl/gpc_palette.sv -----
// palette store: eight color pairs in a ram with per-pair valid bits
// depends on gpc_pkg, gpc_ram and the assertion macro header
`default_nettype none
`include "glyph_pixel_colorizer_assert.svh"

module gpc_palette (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire gpc_pkg::cfg_wr_t                cfg,
  input  wire gpc_pkg::pal_req_t               req,
  output logic      [gpc_pkg::COLOR_W-1:0]     fg_color,
  output logic      [gpc_pkg::COLOR_W-1:0]     bg_color
);
  import gpc_pkg::*;

  logic [PAL_PAIRS-1:0]  pvld;
  logic                  wr_en;
  logic [PAIR_IDX_W-1:0] fg_pair;
  logic [PAIR_IDX_W-1:0] bg_pair;
  logic [PAIR_W-1:0]     fg_word;
  logic [PAIR_W-1:0]     bg_word;
  logic                  fg_hi;
  logic                  bg_hi;
  logic                  fg_ok;
  logic                  bg_ok;

  // writes beyond the last pair are dropped
  assign wr_en   = cfg.we && (cfg.idx < CFG_IDX_W'(PAL_PAIRS));
  assign fg_pair = req.fg_idx[FG_IDX_W-1:1];
  assign bg_pair = PAIR_IDX_W'(req.bg_idx[BG_IDX_W-1:1]);

  gpc_ram #(
    .W (PAIR_W),
    .D (PAL_PAIRS)
  ) u_ram (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (cfg.idx[PAIR_IDX_W-1:0]),
    .wdata   (cfg.data),
    .raddr_a (fg_pair),
    .rdata_a (fg_word),
    .raddr_b (bg_pair),
    .rdata_b (bg_word)
  );

  // a pair never written reads as black
  always_ff @(posedge clk) begin
    if (rst) begin
      pvld <= '0;
    end else if (wr_en) begin
      pvld[cfg.idx[PAIR_IDX_W-1:0]] <= 1'b1;
    end
  end

  // half select and valid flags travel with the ram read
  always_ff @(posedge clk) begin
    fg_hi <= req.fg_idx[0];
    bg_hi <= req.bg_idx[0];
    fg_ok <= pvld[fg_pair];
    bg_ok <= pvld[bg_pair];
  end

  // pick the color within each pair
  always_comb begin
    fg_color = '0;
    bg_color = '0;
    if (fg_ok) begin
      fg_color = fg_hi ? fg_word[PAIR_W-1:COLOR_W] : fg_word[COLOR_W-1:0];
    end
    if (bg_ok) begin
      bg_color = bg_hi ? bg_word[PAIR_W-1:COLOR_W] : bg_word[COLOR_W-1:0];
    end
  end

  // an accepted in-range write marks its pair valid
  `GPC_ASSERT_NXT(a_write_marks_valid, clk, rst, wr_en, pvld[$past(cfg.idx[PAIR_IDX_W-1:0])])

endmodule

`default_nettype wire

// ----- rtl/gpc_chan_blend.sv -----
// one color channel: alpha blend products, rounding and divide by 65025
// depends on gpc_pkg
`default_nettype none

module gpc_chan_blend (
  input  wire logic                        clk,
  input  wire logic [gpc_pkg::CHAN_W-1:0]  alpha,
  input  wire logic [gpc_pkg::CHAN_W-1:0]  glyph,
  input  wire logic [gpc_pkg::CHAN_W-1:0]  fg,
  input  wire logic [gpc_pkg::CHAN_W-1:0]  bg,
  output logic      [gpc_pkg::CHAN_W-1:0]  quot
);
  import gpc_pkg::*;

  logic [PROD_W-1:0] fg_prod;
  logic [PROD_W-1:0] bg_prod;
  logic [CHAN_W-1:0] fg_d;
  logic [NUM_W-1:0]  fg_term;
  logic [NUM_W-1:0]  bg_term;
  logic [NUM_W-1:0]  num;
  logic [NUM_W-1:0]  rem_full;
  logic [CHAN_W-1:0] est;
  logic [REM_W-1:0]  rem;
  logic [1:0]        corr;

  // first products: alpha*glyph and (255-alpha)*bg
  always_ff @(posedge clk) begin
    fg_prod <= PROD_W'(alpha) * PROD_W'(glyph);
    bg_prod <= PROD_W'(CHAN_MAX - alpha) * PROD_W'(bg);
    fg_d    <= fg;
  end

  // second products: times fg, and times 255 as shift and subtract
  always_ff @(posedge clk) begin
    fg_term <= NUM_W'(fg_prod) * NUM_W'(fg_d);
    bg_term <= {bg_prod, {CHAN_W{1'b0}}} - NUM_W'(bg_prod);
  end

  // rounded numerator
  always_ff @(posedge clk) begin
    num <= fg_term + bg_term + ROUND_HALF;
  end

  // quotient estimate from the top byte, and the remainder it leaves
  assign rem_full = num - NUM_W'(num[NUM_W-1:PROD_W]) * FULL_SCALE;

  always_ff @(posedge clk) begin
    est <= num[NUM_W-1:PROD_W];
    rem <= rem_full[REM_W-1:0];
  end

  // the estimate is short by at most two
  always_comb begin
    if (rem >= TWO_R) begin
      corr = 2'd2;
    end else if (rem >= ONE_R) begin
      corr = 2'd1;
    end else begin
      corr = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    quot <= est + CHAN_W'(corr);
  end

endmodule

`default_nettype wire
